[rtl/pxh_pkg.sv]
// ============================================================================
// pxh_pkg
// Shared types and constants of the proxy handshake parser: parse phases,
// job descriptors passed from the front end to the back end, and result
// records.
// ============================================================================
package pxh_pkg;

    // protocol constants
    localparam logic [7:0] SOCKS_VER      = 8'd5;
    localparam logic [7:0] CMD_CONNECT    = 8'd1;
    localparam logic [7:0] CMD_ASSOCIATE  = 8'd3;
    localparam logic [7:0] WIRE_IPV4      = 8'd1;
    localparam logic [7:0] WIRE_DOMAIN    = 8'd3;
    localparam logic [7:0] WIRE_IPV6      = 8'd4;
    localparam logic [7:0] REP_UNREACH    = 8'd4;

    // number of stored target address bytes
    localparam int ADDR_BYTES = 16;
    localparam int ADDR_IDX_W = $clog2(ADDR_BYTES);

    // reported address type
    localparam logic [1:0] AT_IPV4   = 2'd0;
    localparam logic [1:0] AT_DOMAIN = 2'd1;
    localparam logic [1:0] AT_IPV6   = 2'd2;

    // close causes
    localparam logic [2:0] ERR_HEADER   = 3'd0;
    localparam logic [2:0] ERR_COMMAND  = 3'd1;
    localparam logic [2:0] ERR_ATYP     = 3'd2;
    localparam logic [2:0] ERR_DLEN     = 3'd3;
    localparam logic [2:0] ERR_FAMILY   = 3'd4;
    localparam logic [2:0] ERR_UPSTREAM = 3'd5;

    // input operations
    typedef enum logic [1:0] {
        OP_BYTE = 2'd0,
        OP_UP   = 2'd1,
        OP_DOWN = 2'd2
    } t_op;

    // result kinds
    typedef enum logic [2:0] {
        K_REPLY   = 3'd0,
        K_ADDR    = 3'd1,
        K_DONE    = 3'd2,
        K_PAYLOAD = 3'd3,
        K_CLOSE   = 3'd4,
        K_DROP    = 3'd5
    } t_kind;

    // parse phases
    typedef enum logic [2:0] {
        PH_GREET    = 3'd0,
        PH_METHODS  = 3'd1,
        PH_REQUEST  = 3'd2,
        PH_ATYP     = 3'd3,
        PH_DLEN     = 3'd4,
        PH_ADDR     = 3'd5,
        PH_PORT     = 3'd6,
        PH_UPSTREAM = 3'd7
    } t_phase;

    // job types handed to the back end
    typedef enum logic [2:0] {
        J_SINGLE   = 3'd0,
        J_GREET_OK = 3'd1,
        J_REQ_DONE = 3'd2,
        J_ESTAB    = 3'd3,
        J_UP_CLOSE = 3'd4
    } t_job_type;

    typedef struct packed {
        t_job_type  jtype;
        t_kind      kind;   // single jobs only
        logic [7:0] data;   // single jobs only
        logic [2:0] err;    // single close jobs only
        logic       flag;   // upstream close: send unreachable reply first
    } t_job;

    // parsed request, stable once the request is complete
    typedef struct packed {
        logic        associate;
        logic [1:0]  kind;
        logic [7:0]  length;
        logic [15:0] port;
    } t_target;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data;
        logic        command;
        logic [1:0]  atyp;
        logic [7:0]  alen;
        logic [15:0] port;
        logic [2:0]  err;
        logic        last;
    } t_result;

endpackage

[rtl/proxy_handshake_parser.sv]
// ============================================================================
// proxy_handshake_parser
// Server side of a SOCKS5 handshake: parses client bytes and upstream events
// and produces reply, address, request-done, payload and close records.
// ============================================================================
// Input stream: tuser[1:0] is the event (client byte, upstream established,
// upstream closed), tdata[7:0] the client byte. An event is taken whenever
// the job queue has room, one per cycle.
// Output stream: one result record per transaction; tuser is the record
// kind, tlast marks the final record caused by one input event.
// Each accepted event's job is written into the job queue, and the back end
// loads its first record from the queue head into the registered output
// stage. Unless the output stalls, single-record events run at one per cycle
// and reply bursts at one record per cycle (up to 23 for associate IPv6);
// input keeps flowing into the job queue until it (QUEUE_DEPTH jobs) is full.
// Reset (synchronous, active low) returns to the greeting state and clears
// the client port register; stored address bytes are not cleared.
// A stall on the output holds the current record and, once the queue is
// full, holds off the input. Once the connection is closed, events are
// accepted and discarded until reset.
// Configuration: i_cfg_we writes the client port used in the IPv4 associate
// reply; write it while the block is idle.
// ============================================================================
module proxy_handshake_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,     // client_port
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,      // [7:0] data_byte
    input  logic [1:0]  i_s_tuser,      // [1:0] operation
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,      // [7:0] out_byte, [8] command,
                                        // [10:9] target_type,
                                        // [18:11] address_length,
                                        // [34:19] dest_port,
                                        // [37:35] error_code, [39:38] zero
    output logic [2:0]  o_m_tuser,      // [2:0] kind
    output logic        o_m_tlast       // last
);
    import pxh_pkg::*;

    logic                  accept;
    logic                  push;
    t_job                  job;
    t_job                  head;
    logic                  q_empty;
    logic                  q_full;
    logic                  pop;
    t_target               target;
    logic [ADDR_IDX_W-1:0] addr_idx;
    logic [7:0]            addr_byte;
    t_result               result;

    assign o_s_tready = !q_full;
    assign accept     = i_s_tvalid && !q_full;

    // parse front end
    pxh_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_op        (i_s_tuser),
        .i_byte      (i_s_tdata),
        .o_push      (push),
        .o_job       (job),
        .o_target    (target),
        .i_addr_idx  (addr_idx),
        .o_addr_byte (addr_byte)
    );

    // job queue
    pxh_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // record back end
    pxh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_head      (head),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .i_target    (target),
        .o_addr_idx  (addr_idx),
        .i_addr_byte (addr_byte),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_result    (result)
    );

    // output packing
    assign o_m_tdata = {2'b00, result.err, result.port, result.alen,
                        result.atyp, result.command, result.data};
    assign o_m_tuser = result.kind;
    assign o_m_tlast = result.last;

endmodule

[rtl/pxh_front.sv]
// ============================================================================
// pxh_front
// Front end: accepts one event per cycle unless the queue is full, walks the
// handshake state, stores the target address, pushes a job per result event.
// ============================================================================
module pxh_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [1:0]                   i_op,
    input  logic [7:0]                   i_byte,
    output logic                         o_push,
    output pxh_pkg::t_job                o_job,
    output pxh_pkg::t_target             o_target,
    input  logic [pxh_pkg::ADDR_IDX_W-1:0] i_addr_idx,
    output logic [7:0]                   o_addr_byte
);
    import pxh_pkg::*;

    t_phase      r_phase,      n_phase;
    logic [7:0]  r_bytes_left, n_bytes_left;
    logic [1:0]  r_hdr_idx,    n_hdr_idx;
    logic        r_hdr_bad,    n_hdr_bad;
    logic        r_assoc,      n_assoc;
    logic [1:0]  r_tkind,      n_tkind;
    logic [7:0]  r_tlen,       n_tlen;
    logic [15:0] r_tport,      n_tport;
    logic        r_req_sent,   n_req_sent;
    logic        r_up,         n_up;
    logic        r_closed,     n_closed;
    logic [7:0]  r_addr [ADDR_BYTES];
    logic        addr_we;
    logic [7:0]  bytes_dec;

    assign bytes_dec = r_bytes_left - 8'd1;

    // parse state and job generation
    always_comb begin
        n_phase      = r_phase;
        n_bytes_left = r_bytes_left;
        n_hdr_idx    = r_hdr_idx;
        n_hdr_bad    = r_hdr_bad;
        n_assoc      = r_assoc;
        n_tkind      = r_tkind;
        n_tlen       = r_tlen;
        n_tport      = r_tport;
        n_req_sent   = r_req_sent;
        n_up         = r_up;
        n_closed     = r_closed;
        addr_we      = 1'b0;
        o_push       = 1'b0;
        o_job        = '0;
        o_job.jtype  = J_SINGLE;
        o_job.kind   = K_CLOSE;
        if (i_accept && !r_closed) begin
            case (i_op)
                OP_BYTE: begin
                    case (r_phase)
                        PH_GREET: begin
                            if (r_hdr_idx == 2'd0) begin
                                n_hdr_bad = (i_byte != SOCKS_VER);
                                n_hdr_idx = 2'd1;
                            end else if (r_hdr_bad || i_byte == 8'd0) begin
                                o_push    = 1'b1;
                                o_job.err = ERR_HEADER;
                                n_closed  = 1'b1;
                            end else begin
                                n_bytes_left = i_byte;
                                n_phase      = PH_METHODS;
                            end
                        end
                        PH_METHODS: begin
                            n_bytes_left = bytes_dec;
                            if (bytes_dec == 8'd0) begin
                                o_push      = 1'b1;
                                o_job.jtype = J_GREET_OK;
                                n_phase     = PH_REQUEST;
                                n_hdr_idx   = 2'd0;
                                n_hdr_bad   = 1'b0;
                            end
                        end
                        PH_REQUEST: begin
                            if (r_hdr_idx == 2'd0) begin
                                n_hdr_bad = (i_byte != SOCKS_VER);
                                n_hdr_idx = 2'd1;
                            end else if (r_hdr_idx == 2'd1) begin
                                if (i_byte == CMD_CONNECT) begin
                                    n_assoc = 1'b0;
                                end else if (i_byte == CMD_ASSOCIATE) begin
                                    n_assoc = 1'b1;
                                end else begin
                                    n_hdr_bad = 1'b1;
                                end
                                n_hdr_idx = 2'd2;
                            end else if (r_hdr_bad) begin
                                o_push    = 1'b1;
                                o_job.err = ERR_COMMAND;
                                n_closed  = 1'b1;
                            end else begin
                                n_phase = PH_ATYP;
                            end
                        end
                        PH_ATYP: begin
                            n_tlen = 8'd0;
                            if (i_byte == WIRE_IPV4) begin
                                n_tkind      = AT_IPV4;
                                n_bytes_left = 8'd4;
                                n_phase      = PH_ADDR;
                            end else if (i_byte == WIRE_DOMAIN) begin
                                n_tkind = AT_DOMAIN;
                                n_phase = PH_DLEN;
                            end else if (i_byte == WIRE_IPV6) begin
                                n_tkind      = AT_IPV6;
                                n_bytes_left = 8'd16;
                                n_phase      = PH_ADDR;
                            end else begin
                                o_push    = 1'b1;
                                o_job.err = ERR_ATYP;
                                n_closed  = 1'b1;
                            end
                        end
                        PH_DLEN: begin
                            if (i_byte == 8'd0) begin
                                o_push    = 1'b1;
                                o_job.err = ERR_DLEN;
                                n_closed  = 1'b1;
                            end else begin
                                n_bytes_left = i_byte;
                                n_phase      = PH_ADDR;
                            end
                        end
                        PH_ADDR: begin
                            o_push       = 1'b1;
                            o_job.kind   = K_ADDR;
                            o_job.data   = i_byte;
                            addr_we      = (r_tlen < 8'(ADDR_BYTES));
                            n_tlen       = r_tlen + 8'd1;
                            n_bytes_left = bytes_dec;
                            if (bytes_dec == 8'd0) begin
                                n_phase   = PH_PORT;
                                n_hdr_idx = 2'd0;
                            end
                        end
                        PH_PORT: begin
                            if (r_hdr_idx == 2'd0) begin
                                n_tport   = {i_byte, 8'd0};
                                n_hdr_idx = 2'd1;
                            end else begin
                                n_tport     = {r_tport[15:8], i_byte};
                                n_phase     = PH_UPSTREAM;
                                o_push      = 1'b1;
                                o_job.jtype = J_REQ_DONE;
                                if (!r_assoc) begin
                                    n_req_sent = 1'b1;
                                end else if (r_tkind == AT_DOMAIN) begin
                                    n_closed = 1'b1;
                                end
                            end
                        end
                        PH_UPSTREAM: begin
                            o_push     = 1'b1;
                            o_job.kind = r_assoc ? K_DROP : K_PAYLOAD;
                            o_job.data = i_byte;
                        end
                        default: begin
                        end
                    endcase
                end
                OP_UP: begin
                    n_up = 1'b1;
                    if (r_req_sent) begin
                        o_push      = 1'b1;
                        o_job.jtype = J_ESTAB;
                        if (r_tkind == AT_DOMAIN) begin
                            n_closed = 1'b1;
                        end
                    end
                end
                OP_DOWN: begin
                    o_push      = 1'b1;
                    o_job.jtype = J_UP_CLOSE;
                    o_job.flag  = r_req_sent && !r_up;
                    n_closed    = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_GREET;
            r_bytes_left <= 8'd2;
            r_hdr_idx    <= 2'd0;
            r_hdr_bad    <= 1'b0;
            r_assoc      <= 1'b0;
            r_tkind      <= AT_IPV4;
            r_tlen       <= 8'd0;
            r_tport      <= 16'd0;
            r_req_sent   <= 1'b0;
            r_up         <= 1'b0;
            r_closed     <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_bytes_left <= n_bytes_left;
            r_hdr_idx    <= n_hdr_idx;
            r_hdr_bad    <= n_hdr_bad;
            r_assoc      <= n_assoc;
            r_tkind      <= n_tkind;
            r_tlen       <= n_tlen;
            r_tport      <= n_tport;
            r_req_sent   <= n_req_sent;
            r_up         <= n_up;
            r_closed     <= n_closed;
        end
    end

    // target address store, first bytes only
    always_ff @(posedge i_clk) begin
        if (addr_we) begin
            r_addr[r_tlen[ADDR_IDX_W-1:0]] <= i_byte;
        end
    end

    assign o_addr_byte        = r_addr[i_addr_idx];
    assign o_target.associate = r_assoc;
    assign o_target.kind      = r_tkind;
    assign o_target.length    = r_tlen;
    assign o_target.port      = r_tport;

endmodule

[rtl/pxh_queue.sv]
// ============================================================================
// pxh_queue
// Small job queue between the front end and the back end, so that a stall on
// either side holds up the other only once the queue is full or empty.
// ============================================================================
module pxh_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pxh_pkg::t_job   i_job,
    input  logic            i_pop,
    output pxh_pkg::t_job   o_head,
    output logic            o_empty,
    output logic            o_full
);
    import pxh_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             do_push;
    logic             do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    // pointer and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

[rtl/pxh_back.sv]
// ============================================================================
// pxh_back
// Back end: expands the job at the queue head into result records, one per
// cycle unless the output stalls, into a registered output stage.
// ============================================================================
module pxh_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [15:0]                    i_cfg_data,
    input  pxh_pkg::t_job                  i_head,
    input  logic                           i_empty,
    output logic                           o_pop,
    input  pxh_pkg::t_target               i_target,
    output logic [pxh_pkg::ADDR_IDX_W-1:0] o_addr_idx,
    input  logic [7:0]                     i_addr_byte,
    output logic                           o_valid,
    input  logic                           i_ready,
    output pxh_pkg::t_result               o_result
);
    import pxh_pkg::*;

    logic [15:0] r_client_port;
    logic [4:0]  r_step,  n_step;
    logic        r_valid, n_valid;
    t_result     r_result;
    t_result     res;
    logic        load;
    logic        last_step;
    logic [4:0]  rs;
    logic [4:0]  rep_n;
    logic [4:0]  addr_off;
    logic        is_v6;
    logic        is_dom;
    logic [15:0] rep_port;
    logic [7:0]  rep_byte;
    logic        rep_last;

    // client port register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_client_port <= 16'd0;
        end else if (i_cfg_we) begin
            r_client_port <= i_cfg_data;
        end
    end

    // success reply byte at reply position rs
    assign is_v6    = (i_target.kind == AT_IPV6);
    assign is_dom   = (i_target.kind == AT_DOMAIN);
    assign rs       = (i_head.jtype == J_REQ_DONE) ? r_step - 5'd1 : r_step;
    assign rep_n    = is_v6 ? 5'd16 : 5'd4;
    assign addr_off = rs - 5'd4;
    assign o_addr_idx = addr_off[ADDR_IDX_W-1:0];
    assign rep_port = (i_head.jtype == J_REQ_DONE && i_target.kind == AT_IPV4) ?
                      r_client_port : i_target.port;
    assign rep_last = (rs == rep_n + 5'd5);

    always_comb begin
        if (rs == 5'd0) begin
            rep_byte = SOCKS_VER;
        end else if (rs == 5'd1 || rs == 5'd2) begin
            rep_byte = 8'd0;
        end else if (rs == 5'd3) begin
            rep_byte = is_v6 ? WIRE_IPV6 : WIRE_IPV4;
        end else if (rs < rep_n + 5'd4) begin
            rep_byte = i_addr_byte;
        end else if (rs == rep_n + 5'd4) begin
            rep_byte = rep_port[15:8];
        end else begin
            rep_byte = rep_port[7:0];
        end
    end

    // result record for the current job step
    always_comb begin
        res       = '0;
        res.kind  = K_REPLY;
        last_step = 1'b1;
        case (i_head.jtype)
            J_SINGLE: begin
                res.kind = i_head.kind;
                res.data = i_head.data;
                res.err  = i_head.err;
            end
            J_GREET_OK: begin
                res.data  = (r_step == 5'd0) ? SOCKS_VER : 8'd0;
                last_step = (r_step == 5'd1);
            end
            J_REQ_DONE: begin
                if (r_step == 5'd0) begin
                    res.kind    = K_DONE;
                    res.command = i_target.associate;
                    res.atyp    = i_target.kind;
                    res.alen    = i_target.length;
                    res.port    = i_target.port;
                    last_step   = !i_target.associate;
                end else if (is_dom) begin
                    res.kind = K_CLOSE;
                    res.err  = ERR_FAMILY;
                end else begin
                    res.data  = rep_byte;
                    last_step = rep_last;
                end
            end
            J_ESTAB: begin
                if (is_dom) begin
                    res.kind = K_CLOSE;
                    res.err  = ERR_FAMILY;
                end else begin
                    res.data  = rep_byte;
                    last_step = rep_last;
                end
            end
            J_UP_CLOSE: begin
                if (i_head.flag && r_step < 5'd10) begin
                    last_step = 1'b0;
                    case (r_step)
                        5'd0:    res.data = SOCKS_VER;
                        5'd1:    res.data = REP_UNREACH;
                        5'd3:    res.data = WIRE_IPV4;
                        default: res.data = 8'd0;
                    endcase
                end else begin
                    res.kind = K_CLOSE;
                    res.err  = ERR_UPSTREAM;
                end
            end
            default: begin
            end
        endcase
        res.last = last_step;
    end

    // output stage and step sequencing
    assign load  = !i_empty && (!r_valid || i_ready);
    assign o_pop = load && last_step;

    always_comb begin
        n_step  = r_step;
        n_valid = r_valid && !i_ready;
        if (load) begin
            n_valid = 1'b1;
            n_step  = last_step ? 5'd0 : r_step + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= 5'd0;
            r_valid <= 1'b0;
        end else begin
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= res;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for proxy_handshake_parser. A behavioral copy of the
// handshake state machine predicts the records of every accepted transaction.
// The checker compares each output record field by field against the oldest
// prediction. One connection is walked from greeting to upstream close, with
// random payload traffic, upstream events and output backpressure in between.
// ============================================================================
module tb_top;
    import pxh_pkg::*;

    localparam int          HALF_PERIOD    = 6;
    localparam int          RESET_CYCLES   = 7;
    localparam int          DRAIN_CYCLES   = 10;
    localparam int          HOLD_CYCLES    = 90;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam logic [1:0]  OP_NONE        = 2'd3;  // reserved event, ignored by the block
    localparam logic [7:0]  REP_OK         = 8'd0;
    localparam logic [7:0]  AUTH_NONE      = 8'd0;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_cfg_we   = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata  = '0;
    logic [1:0]  i_s_tuser  = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;
    logic [2:0]  o_m_tuser;
    logic        o_m_tlast;

    proxy_handshake_parser i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // stream pacing and bookkeeping
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    bit      hold_request  = 1'b0;
    int      hold_left     = 0;
    int      idle_cycles   = 0;
    int      mismatch_count = 0;
    t_result expected_records [$];
    t_result step_records [$];

    // handshake model state
    t_phase      ph           = PH_GREET;
    logic [7:0]  left_cnt     = 8'd2;
    logic [1:0]  hdr_idx      = '0;
    logic        hdr_bad      = 1'b0;
    logic        assoc        = 1'b0;
    logic [1:0]  tgt_kind     = AT_IPV4;
    logic [7:0]  tgt_len      = '0;
    logic [7:0]  tgt_addr [ADDR_BYTES];
    logic [15:0] tgt_port     = '0;
    logic        req_issued   = 1'b0;
    logic        up_seen      = 1'b0;
    logic        conn_closed  = 1'b0;
    logic [15:0] model_client_port = '0;

    // ------------------------------------------------------------------------
    // handshake model
    // ------------------------------------------------------------------------
    function automatic void push_record(t_kind kind, logic [7:0] data, logic cmd,
                                        logic [1:0] at, logic [7:0] alen,
                                        logic [15:0] port, logic [2:0] err);
        t_result rec;
        rec.kind    = kind;
        rec.data    = data;
        rec.command = cmd;
        rec.atyp    = at;
        rec.alen    = alen;
        rec.port    = port;
        rec.err     = err;
        rec.last    = 1'b0;
        step_records.push_back(rec);
    endfunction

    function automatic void push_reply(logic [7:0] data);
        push_record(K_REPLY, data, 1'b0, '0, '0, '0, '0);
    endfunction

    function automatic void close_connection(logic [2:0] err);
        push_record(K_CLOSE, 8'h00, 1'b0, '0, '0, '0, err);
        conn_closed = 1'b1;
    endfunction

    // success or bind reply with the stored target; returns 0 for a domain target
    function automatic bit push_success_reply(logic [15:0] port);
        int count;
        if (tgt_kind == AT_IPV4) count = 4;
        else if (tgt_kind == AT_IPV6) count = ADDR_BYTES;
        else return 1'b0;
        push_reply(SOCKS_VER);
        push_reply(REP_OK);
        push_reply(8'h00);
        push_reply(count == 4 ? WIRE_IPV4 : WIRE_IPV6);
        for (int i = 0; i < count; i++) push_reply(tgt_addr[i]);
        push_reply(port[15:8]);
        push_reply(port[7:0]);
        return 1'b1;
    endfunction

    function automatic void model_client_byte(logic [7:0] b);
        case (ph)
            PH_GREET: begin
                if (hdr_idx == 2'd0) begin
                    hdr_bad = (b != SOCKS_VER);
                    hdr_idx = 2'd1;
                end else if (hdr_bad || b == 8'd0) begin
                    close_connection(ERR_HEADER);
                end else begin
                    left_cnt = b;
                    ph = PH_METHODS;
                end
            end
            PH_METHODS: begin
                left_cnt = left_cnt - 8'd1;
                if (left_cnt == 8'd0) begin
                    push_reply(SOCKS_VER);
                    push_reply(AUTH_NONE);
                    ph = PH_REQUEST;
                    hdr_idx = 2'd0;
                    hdr_bad = 1'b0;
                end
            end
            PH_REQUEST: begin
                if (hdr_idx == 2'd0) begin
                    hdr_bad = (b != SOCKS_VER);
                    hdr_idx = 2'd1;
                end else if (hdr_idx == 2'd1) begin
                    if (b == CMD_CONNECT) assoc = 1'b0;
                    else if (b == CMD_ASSOCIATE) assoc = 1'b1;
                    else hdr_bad = 1'b1;
                    hdr_idx = 2'd2;
                end else if (hdr_bad) begin
                    close_connection(ERR_COMMAND);
                end else begin
                    ph = PH_ATYP;
                end
            end
            PH_ATYP: begin
                tgt_len = 8'd0;
                if (b == WIRE_IPV4) begin
                    tgt_kind = AT_IPV4;
                    left_cnt = 8'd4;
                    ph = PH_ADDR;
                end else if (b == WIRE_DOMAIN) begin
                    tgt_kind = AT_DOMAIN;
                    ph = PH_DLEN;
                end else if (b == WIRE_IPV6) begin
                    tgt_kind = AT_IPV6;
                    left_cnt = 8'(ADDR_BYTES);
                    ph = PH_ADDR;
                end else begin
                    close_connection(ERR_ATYP);
                end
            end
            PH_DLEN: begin
                if (b == 8'd0) begin
                    close_connection(ERR_DLEN);
                end else begin
                    left_cnt = b;
                    ph = PH_ADDR;
                end
            end
            PH_ADDR: begin
                push_record(K_ADDR, b, 1'b0, '0, '0, '0, '0);
                // long domains keep only the first stored bytes
                if (tgt_len < ADDR_BYTES) tgt_addr[tgt_len[ADDR_IDX_W-1:0]] = b;
                tgt_len = tgt_len + 8'd1;
                left_cnt = left_cnt - 8'd1;
                if (left_cnt == 8'd0) begin
                    ph = PH_PORT;
                    hdr_idx = 2'd0;
                end
            end
            PH_PORT: begin
                if (hdr_idx == 2'd0) begin
                    tgt_port = {b, 8'h00};
                    hdr_idx = 2'd1;
                end else begin
                    tgt_port[7:0] = b;
                    ph = PH_UPSTREAM;
                    push_record(K_DONE, 8'h00, assoc, tgt_kind, tgt_len, tgt_port, '0);
                    if (!assoc) begin
                        req_issued = 1'b1;
                    end else if (!push_success_reply(tgt_kind == AT_IPV4 ?
                                                     model_client_port : tgt_port)) begin
                        close_connection(ERR_FAMILY);
                    end
                end
            end
            PH_UPSTREAM: begin
                push_record(assoc ? K_DROP : K_PAYLOAD, b, 1'b0, '0, '0, '0, '0);
            end
            default: ;
        endcase
    endfunction

    // predict the records of one accepted transaction
    function automatic void predict_event(logic [1:0] op, logic [7:0] b);
        step_records.delete();
        if (conn_closed) return;
        if (op == OP_BYTE) begin
            model_client_byte(b);
        end else if (op == OP_UP) begin
            up_seen = 1'b1;
            if (req_issued && !push_success_reply(tgt_port)) close_connection(ERR_FAMILY);
        end else if (op == OP_DOWN) begin
            // connect issued but never established: host unreachable first
            if (req_issued && !up_seen) begin
                push_reply(SOCKS_VER);
                push_reply(REP_UNREACH);
                push_reply(8'h00);
                push_reply(WIRE_IPV4);
                for (int i = 0; i < 6; i++) push_reply(8'h00);
            end
            close_connection(ERR_UPSTREAM);
        end
        if (step_records.size() > 0) begin
            step_records[step_records.size() - 1].last = 1'b1;
            foreach (step_records[i]) expected_records.push_back(step_records[i]);
        end
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    function automatic void check_record();
        t_result exp_rec;
        if (expected_records.size() == 0) begin
            $error("unexpected record: kind %0d, tdata 0x%0h", o_m_tuser, o_m_tdata);
            mismatch_count++;
            return;
        end
        exp_rec = expected_records.pop_front();
        check_field("kind", 16'(exp_rec.kind), 16'(o_m_tuser));
        check_field("out_byte", 16'(exp_rec.data), 16'(o_m_tdata[7:0]));
        check_field("command", 16'(exp_rec.command), 16'(o_m_tdata[8]));
        check_field("target_type", 16'(exp_rec.atyp), 16'(o_m_tdata[10:9]));
        check_field("address_length", 16'(exp_rec.alen), 16'(o_m_tdata[18:11]));
        check_field("dest_port", exp_rec.port, o_m_tdata[34:19]);
        check_field("error_code", 16'(exp_rec.err), 16'(o_m_tdata[37:35]));
        check_field("last", 16'(exp_rec.last), 16'(o_m_tlast));
    endfunction

    // sample both streams at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready) predict_event(i_s_tuser, i_s_tdata);
        if (i_rst_n && o_m_tvalid && i_m_tready) check_record();
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle_cycles = 0;
        else idle_cycles++;
    end

    // receiver: random stalls, plus a long hold when requested
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin : watchdog
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send_event(input logic [1:0] op, input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= 8'($urandom_range(255));
            i_s_tuser  <= 2'($urandom_range(3));
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_event(OP_BYTE, b);
    endtask

    // stop offering and let every expected record come out
    task automatic wait_drained();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (expected_records.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_client_port(input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        model_client_port = value;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_greeting();
        write_client_port(16'hFFFF);
        send_byte(SOCKS_VER);
        send_byte(8'd2);
        send_byte(8'h00);
        send_byte(8'hFF);
        wait_drained();
        write_client_port(16'h0000);
    endtask

    // connect request to an ipv6 target with extreme address and port bytes
    task automatic test_connect_request();
        send_byte(SOCKS_VER);
        send_byte(CMD_CONNECT);
        send_byte(8'hFF);
        send_byte(WIRE_IPV6);
        send_byte(8'h00);
        send_byte(8'hFF);
        for (int i = 2; i < ADDR_BYTES; i++) send_byte(8'($urandom_range(255)));
        send_byte(8'hFF);
        send_byte(8'h00);
        wait_drained();
        write_client_port(16'($urandom_range(65535)));
    endtask

    // established twice, an ignored event and boundary payload bytes
    task automatic test_upstream_events();
        send_event(OP_UP, 8'h00);
        send_event(OP_NONE, 8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_event(OP_UP, 8'hFF);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int n_items);
        int         pick;
        logic [1:0] op;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(99);
            if (pick < 6) op = OP_UP;
            else if (pick < 11) op = OP_NONE;
            else op = OP_BYTE;
            send_event(op, 8'($urandom_range(255)));
        end
        wait_drained();
        write_client_port(16'($urandom_range(65535)));
    endtask

    // long output hold while reply bursts and payload keep coming
    task automatic test_backpressure();
        send_idle_pct = 0;
        hold_request = 1'b1;
        for (int i = 0; i < 24; i++) begin
            if (i % 8 == 0) send_event(OP_UP, 8'($urandom_range(255)));
            else send_byte(8'($urandom_range(255)));
        end
        wait_drained();
    endtask

    // upstream close ends the connection; later events give nothing
    task automatic test_upstream_close();
        send_event(OP_DOWN, 8'($urandom_range(255)));
        for (int i = 0; i < 6; i++) send_event(2'($urandom_range(3)), 8'($urandom_range(255)));
        wait_drained();
    endtask

    initial begin : main
        foreach (tgt_addr[i]) tgt_addr[i] = '0;
        send_idle_pct = 26;
        recv_idle_pct = 53;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_greeting();
        test_connect_request();
        test_upstream_events();
        test_random_traffic(26, 53, 140);
        test_backpressure();
        test_random_traffic(53, 26, 140);
        test_random_traffic(0, 0, 140);
        test_upstream_close();

        if (mismatch_count == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule
